### rtl/core/mmgn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmgn_pkg
// Shared types and constants of the min/max gray normalizer: command codes,
// controller states and the command bundle from controller to datapath.
// ----------------------------------------------------------------------------
package mmgn_pkg;

   localparam int GRAY_BITS  = 8;
   localparam int GRAY_FULL  = 255;
   localparam int QUOT_STEPS = GRAY_BITS;
   localparam int STEP_BITS  = $clog2(QUOT_STEPS);

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2
   } cmd_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_PREP,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic write_en;
      logic clear_ext;
      logic capture_read;
      logic fetch;
      logic prep;
      logic div_step;
      logic load_result;
   } ctrl_cmd_type;

endpackage
`default_nettype wire

### rtl/core/min_max_gray_normalizer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// min_max_gray_normalizer_unit
// Min/max normalizer of a square grid of signed samples to 8-bit gray levels.
// ----------------------------------------------------------------------------
// Start and write transactions leave the controller idle, so the next
// transaction is accepted in the following cycle. A read goes through these
// steps in order: the cell address is registered, the memory read is
// registered, the value is clamped and scaled by 255, the restoring divider
// produces one gray bit per cycle, and the result register is loaded; that
// last step repeats while an earlier result is still held by a stalled
// result side. The result register holds a finished read while further start
// and write transactions are accepted. Out-of-grid writes are dropped;
// reading a cell not written since reset returns an undefined gray level.
module min_max_gray_normalizer_unit #(
   parameter int  GRID_SIZE   = 64,
   parameter int  SAMPLE_BITS = 24,
   localparam int ROW_BITS    = $clog2(GRID_SIZE)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_cmd,
   input  wire logic [ROW_BITS-1:0]           req_row,
   input  wire logic [ROW_BITS-1:0]           req_col,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [mmgn_pkg::GRAY_BITS-1:0]     rsp_gray,
   output logic                               rsp_range_zero
);
   import mmgn_pkg::*;

   ctrl_cmd_type cmd;

   mmgn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   mmgn_datapath #(
      .GRID_SIZE   (GRID_SIZE),
      .SAMPLE_BITS (SAMPLE_BITS),
      .ROW_BITS    (ROW_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_sample     (req_sample),
      .rsp_gray       (rsp_gray),
      .rsp_range_zero (rsp_range_zero)
   );

endmodule
`default_nettype wire

### rtl/core/mmgn_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmgn_ctrl
// Controller: accepts transactions, sequences the read through fetch, prep
// and the bit-serial divide, and owns the result valid register.
// ----------------------------------------------------------------------------
module mmgn_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_cmd,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output mmgn_pkg::ctrl_cmd_type     cmd
);
   import mmgn_pkg::*;

   state_type             state_ff, state_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_START: cmd.clear_ext = 1'b1;
                  CMD_WRITE: cmd.write_en  = 1'b1;
                  CMD_READ: begin
                     cmd.capture_read = 1'b1;
                     state_in         = ST_FETCH;
                  end
                  default: ;
               endcase
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            step_in  = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(QUOT_STEPS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_result = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

### rtl/core/mmgn_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmgn_datapath
// Datapath: cell memory, running extremes, clamp and scale by 255, restoring
// divider with one quotient bit per cycle, and the result payload register.
// ----------------------------------------------------------------------------
module mmgn_datapath #(
   parameter int GRID_SIZE   = 64,
   parameter int SAMPLE_BITS = 24,
   parameter int ROW_BITS    = 6
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire mmgn_pkg::ctrl_cmd_type              cmd,
   input  wire logic [ROW_BITS-1:0]                 req_row,
   input  wire logic [ROW_BITS-1:0]                 req_col,
   input  wire logic signed [SAMPLE_BITS-1:0]       req_sample,
   output logic [mmgn_pkg::GRAY_BITS-1:0]           rsp_gray,
   output logic                                     rsp_range_zero
);
   import mmgn_pkg::*;

   localparam int CELLS     = GRID_SIZE * GRID_SIZE;
   localparam int ADDR_BITS = $clog2(CELLS);
   localparam logic [ROW_BITS:0]    GRID_LIM = (ROW_BITS + 1)'(GRID_SIZE);
   localparam logic [ADDR_BITS-1:0] GRID_A   = ADDR_BITS'(GRID_SIZE);

   logic signed [SAMPLE_BITS-1:0] mem [CELLS];

   logic signed [SAMPLE_BITS-1:0] min_ff, max_ff;
   logic [ADDR_BITS-1:0]          addr_ff;
   logic                          oob_ff;
   logic signed [SAMPLE_BITS-1:0] mem_q_ff;
   logic [SAMPLE_BITS-1:0]        rem_ff, range_ff;
   logic [GRAY_BITS-1:0]          low_ff, quot_ff;
   logic                          force_zero_ff, flag_ff;
   logic [GRAY_BITS-1:0]          gray_ff;
   logic                          range_zero_ff;

   logic                          in_grid;
   logic [ADDR_BITS-1:0]          addr;
   logic signed [SAMPLE_BITS-1:0] clamped;
   logic [SAMPLE_BITS:0]          diff_w, range_w;
   logic [SAMPLE_BITS-1:0]        diff, range_v;
   logic [SAMPLE_BITS+GRAY_BITS-1:0] num;
   logic [SAMPLE_BITS:0]          trial;
   logic                          take;

   assign in_grid = ({1'b0, req_row} < GRID_LIM) && ({1'b0, req_col} < GRID_LIM);
   assign addr    = ADDR_BITS'(req_row) * GRID_A + ADDR_BITS'(req_col);

   // extremes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0;
         max_ff <= '0;
      end else if (cmd.clear_ext) begin
         min_ff <= '0;
         max_ff <= '0;
      end else if (cmd.write_en && in_grid) begin
         if (req_sample < min_ff) begin
            min_ff <= req_sample;
         end
         if (req_sample > max_ff) begin
            max_ff <= req_sample;
         end
      end
   end

   // cell memory
   always_ff @(posedge clock) begin
      if (cmd.write_en && in_grid) begin
         mem[addr] <= req_sample;
      end
      if (cmd.fetch) begin
         mem_q_ff <= mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture_read) begin
         addr_ff <= addr;
         oob_ff  <= !in_grid;
      end
   end

   // clamp stale values, scale by 255
   always_comb begin
      clamped = mem_q_ff;
      if (clamped < min_ff) begin
         clamped = min_ff;
      end
      if (clamped > max_ff) begin
         clamped = max_ff;
      end
      diff_w  = {clamped[SAMPLE_BITS-1], clamped} - {min_ff[SAMPLE_BITS-1], min_ff};
      range_w = {max_ff[SAMPLE_BITS-1], max_ff} - {min_ff[SAMPLE_BITS-1], min_ff};
      diff    = diff_w[SAMPLE_BITS-1:0];
      range_v = range_w[SAMPLE_BITS-1:0];
      num     = {diff, {GRAY_BITS{1'b0}}} - (SAMPLE_BITS + GRAY_BITS)'(diff);
   end

   // restoring divide step
   assign trial = {rem_ff, low_ff[GRAY_BITS-1]};
   assign take  = (trial >= {1'b0, range_ff});

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         rem_ff        <= num[SAMPLE_BITS+GRAY_BITS-1:GRAY_BITS];
         low_ff        <= num[GRAY_BITS-1:0];
         range_ff      <= range_v;
         quot_ff       <= '0;
         flag_ff       <= (range_v == '0);
         force_zero_ff <= (range_v == '0) || oob_ff;
      end else if (cmd.div_step) begin
         if (take) begin
            rem_ff <= SAMPLE_BITS'(trial - {1'b0, range_ff});
         end else begin
            rem_ff <= trial[SAMPLE_BITS-1:0];
         end
         low_ff  <= {low_ff[GRAY_BITS-2:0], 1'b0};
         quot_ff <= {quot_ff[GRAY_BITS-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         gray_ff       <= force_zero_ff ? '0 : quot_ff;
         range_zero_ff <= flag_ff;
      end
   end

   assign rsp_gray       = gray_ff;
   assign rsp_range_zero = range_zero_ff;

endmodule
`default_nettype wire

### rtl/core/mmgn_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmgn_checker
// Port-level checks of the normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module mmgn_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_stall,
   input wire logic [1:0]                req_cmd,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire logic [mmgn_pkg::GRAY_BITS-1:0] rsp_gray,
   input wire logic                      rsp_range_zero
);
   import mmgn_pkg::*;

   logic req_take;

   assign req_take = req_valid && !req_stall;

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_gray) && $stable(rsp_range_zero))
      else $error("stalled result changed");

   // a read keeps the request side stalled while it is worked on
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_cmd == CMD_READ) |=> req_stall ##1 req_stall)
      else $error("request accepted during read");

   // start and write leave the request side free in the cycle after they are taken
   a_short_cmd: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_cmd == CMD_START || req_cmd == CMD_WRITE) |=> !req_stall)
      else $error("short transaction stalled the request side");

   // zero range forces a zero gray level
   a_zero_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_zero |-> rsp_gray == '0)
      else $error("zero range with nonzero gray");

endmodule

bind min_max_gray_normalizer_unit mmgn_checker u_mmgn_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_cmd        (req_cmd),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_gray       (rsp_gray),
   .rsp_range_zero (rsp_range_zero)
);
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for min_max_gray_normalizer_unit. A directed table
// walks the sample extremes, zero range, stale cells, clamping and the unused
// command code, then a random mix of frame starts, unused codes, writes and
// reads of written cells follows. Each read is checked against the table or
// a cycle-free predictor that mirrors the cell store and running extremes.
// The sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;
   import mmgn_pkg::*;

   localparam int GRID         = 64;
   localparam int SMP_BITS     = 24;
   localparam int CELLS        = GRID * GRID;
   localparam int DIR_ROWS     = 26;
   localparam int RANDOM_ITEMS = 600;
   localparam int PAUSE_AT     = 300;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 24;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]                 cmd;
      logic [5:0]                 row;
      logic [5:0]                 col;
      logic signed [SMP_BITS-1:0] sample;
      bit                         typed;
      logic [GRAY_BITS-1:0]       gray;
      logic                       range_zero;
   } stim_row_type;

   typedef struct {
      logic [GRAY_BITS-1:0] gray;
      logic                 range_zero;
   } gray_result_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY
   } stall_mode_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_valid  = 1'b0;
   logic [1:0]                 req_cmd    = CMD_START;
   logic [5:0]                 req_row    = '0;
   logic [5:0]                 req_col    = '0;
   logic signed [SMP_BITS-1:0] req_sample = '0;
   logic                       rsp_stall  = 1'b0;
   logic                       req_stall;
   logic                       rsp_valid;
   logic [GRAY_BITS-1:0]       rsp_gray;
   logic                       rsp_range_zero;

   logic signed [SMP_BITS-1:0] cell_mirror [CELLS];
   bit                         cell_written [CELLS];
   int unsigned                written_q [$];
   logic signed [SMP_BITS-1:0] mirror_min = '0;
   logic signed [SMP_BITS-1:0] mirror_max = '0;
   gray_result_type            gray_expect_q [$];

   stim_row_type   dir_tab [DIR_ROWS];
   int             burst_left  = 0;
   int             idle_cycles = 0;
   int             mismatches  = 0;
   int             n_start     = 0;
   int             n_write     = 0;
   int             n_read      = 0;
   int             n_unused    = 0;
   int             n_checked   = 0;
   int             n_zero      = 0;
   stall_mode_type stall_mode  = STALL_NONE;
   int             stall_left  = 0;

   always #10 clock = ~clock;

   min_max_gray_normalizer_unit #(
      .GRID_SIZE   (GRID),
      .SAMPLE_BITS (SMP_BITS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_gray       (rsp_gray),
      .rsp_range_zero (rsp_range_zero)
   );

   function automatic gray_result_type norm_gray(input int unsigned idx);
      gray_result_type res;
      longint          lo;
      longint          hi;
      longint          rng;
      longint          v;
      lo = mirror_min;
      hi = mirror_max;
      rng = hi - lo;
      res.range_zero = (rng == 0);
      res.gray = '0;
      if (rng > 0) begin
         v = cell_mirror[idx];
         if (v < lo) v = lo;
         if (v > hi) v = hi;
         res.gray = GRAY_BITS'(((v - lo) * GRAY_FULL) / rng);
      end
      return res;
   endfunction

   function automatic void report_fault(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
   endfunction

   // drive one transaction and fold it into the mirror once accepted
   task automatic send_txn(input logic [1:0] cmd, input logic [5:0] row,
                           input logic [5:0] col, input logic signed [SMP_BITS-1:0] smp,
                           input bit typed, input logic [GRAY_BITS-1:0] t_gray,
                           input logic t_zero);
      int unsigned     idx;
      gray_result_type res;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid  <= 1'b1;
      req_cmd    <= cmd;
      req_row    <= row;
      req_col    <= col;
      req_sample <= smp;
      do @(posedge clock); while (req_stall);
      idx = {20'd0, row, col};
      case (cmd)
         CMD_START: begin
            mirror_min = '0;
            mirror_max = '0;
            n_start++;
         end
         CMD_WRITE: begin
            cell_mirror[idx] = smp;
            if (!cell_written[idx]) begin
               cell_written[idx] = 1'b1;
               written_q.push_back(idx);
            end
            if (smp < mirror_min) mirror_min = smp;
            if (smp > mirror_max) mirror_max = smp;
            n_write++;
         end
         CMD_READ: begin
            if (typed) begin
               res.gray = t_gray;
               res.range_zero = t_zero;
            end else begin
               res = norm_gray(idx);
            end
            gray_expect_q.push_back(res);
            n_read++;
         end
         default: n_unused++;
      endcase
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 2));
         stall_left <= $urandom_range(32, 160);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         default:     rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin : check_results
      gray_result_type exp_res;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (gray_expect_q.size() == 0) begin
               report_fault($sformatf("unexpected result gray=%0d range_zero=%0b",
                                      rsp_gray, rsp_range_zero));
            end else begin
               exp_res = gray_expect_q.pop_front();
               if (rsp_gray !== exp_res.gray)
                  report_fault($sformatf("result %0d gray expected %0d got %0d",
                                         n_checked, exp_res.gray, rsp_gray));
               if (rsp_range_zero !== exp_res.range_zero)
                  report_fault($sformatf("result %0d range_zero expected %0b got %0b",
                                         n_checked, exp_res.range_zero, rsp_range_zero));
               if (exp_res.range_zero) n_zero++;
               n_checked++;
            end
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int unsigned                idx;
      int                         n;
      int                         pick;
      int                         span;
      logic [5:0]                 row;
      logic [5:0]                 col;
      logic signed [SMP_BITS-1:0] smp;

      // cmd, row, col, sample, typed, gray, range_zero
      dir_tab = '{
         '{CMD_WRITE,  6'd0,  6'd0,  24'sd0,       1'b0, 8'd0,   1'b0},
         '{CMD_READ,   6'd0,  6'd0,  24'sd0,       1'b1, 8'd0,   1'b1},
         '{CMD_WRITE,  6'd63, 6'd63, 24'sh7FFFFF,  1'b0, 8'd0,   1'b0},
         '{CMD_READ,   6'd63, 6'd63, 24'sd0,       1'b1, 8'd255, 1'b0},
         '{CMD_READ,   6'd0,  6'd0,  24'sd0,       1'b1, 8'd0,   1'b0},
         '{CMD_WRITE,  6'd0,  6'd63, 24'sh800000,  1'b0, 8'd0,   1'b0},
         '{CMD_READ,   6'd0,  6'd63, 24'sd0,       1'b1, 8'd0,   1'b0},
         '{CMD_READ,   6'd63, 6'd63, 24'sd0,       1'b1, 8'd255, 1'b0},
         '{CMD_READ,   6'd0,  6'd0,  24'sd0,       1'b0, 8'd0,   1'b0},
         '{CMD_UNUSED, 6'd42, 6'd21, 24'sh5A5A5A,  1'b0, 8'd0,   1'b0},
         '{CMD_START,  6'd63, 6'd63, 24'shFFFFFF,  1'b0, 8'd0,   1'b0},
         '{CMD_READ,   6'd63, 6'd63, 24'sd0,       1'b1, 8'd0,   1'b1},
         '{CMD_WRITE,  6'd5,  6'd7,  24'sd100,     1'b0, 8'd0,   1'b0},
         '{CMD_READ,   6'd0,  6'd63, 24'sd0,       1'b1, 8'd0,   1'b0},
         '{CMD_READ,   6'd63, 6'd63, 24'sd0,       1'b1, 8'd255, 1'b0},
         '{CMD_READ,   6'd5,  6'd7,  24'sd0,       1'b1, 8'd255, 1'b0},
         '{CMD_WRITE,  6'd63, 6'd0,  24'shFFFFFF,  1'b0, 8'd0,   1'b0},
         '{CMD_READ,   6'd63, 6'd0,  24'sd0,       1'b1, 8'd0,   1'b0},
         '{CMD_READ,   6'd0,  6'd0,  24'sd0,       1'b0, 8'd0,   1'b0},
         '{CMD_WRITE,  6'd21, 6'd42, 24'sd50,      1'b0, 8'd0,   1'b0},
         '{CMD_READ,   6'd21, 6'd42, 24'sd0,       1'b0, 8'd0,   1'b0},
         '{CMD_WRITE,  6'd1,  6'd1,  24'sh7FFFFF,  1'b0, 8'd0,   1'b0},
         '{CMD_WRITE,  6'd1,  6'd2,  24'sh800000,  1'b0, 8'd0,   1'b0},
         '{CMD_READ,   6'd1,  6'd2,  24'sd0,       1'b1, 8'd0,   1'b0},
         '{CMD_READ,   6'd1,  6'd1,  24'sd0,       1'b1, 8'd255, 1'b0},
         '{CMD_READ,   6'd0,  6'd0,  24'sd0,       1'b0, 8'd0,   1'b0}
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_txn(dir_tab[i].cmd, dir_tab[i].row, dir_tab[i].col, dir_tab[i].sample,
                  dir_tab[i].typed, dir_tab[i].gray, dir_tab[i].range_zero);
      end

      n = 0;
      while (n < RANDOM_ITEMS) begin
         if (n == PAUSE_AT) begin
            // let the pipeline drain completely before going on
            req_valid <= 1'b0;
            do @(negedge clock); while (gray_expect_q.size() != 0);
            burst_left = 0;
         end
         pick = $urandom_range(0, 99);
         row = 6'($urandom);
         col = 6'($urandom);
         if (pick < 3) begin
            send_txn(CMD_START, row, col, SMP_BITS'($urandom), 1'b0, '0, 1'b0);
            n++;
         end else if (pick < 6) begin
            send_txn(CMD_UNUSED, row, col, SMP_BITS'($urandom), 1'b0, '0, 1'b0);
         end else if (pick < 52 || written_q.size() == 0) begin
            case ($urandom_range(0, 2))
               0: smp = SMP_BITS'($urandom);
               1: begin
                  span = int'($urandom_range(0, 400)) - 200;
                  smp = span[SMP_BITS-1:0];
               end
               default: begin
                  span = int'($urandom_range(0, 131072)) - 65536;
                  smp = span[SMP_BITS-1:0];
               end
            endcase
            send_txn(CMD_WRITE, row, col, smp, 1'b0, '0, 1'b0);
            n++;
         end else begin
            idx = written_q[$urandom_range(0, written_q.size() - 1)];
            send_txn(CMD_READ, idx[11:6], idx[5:0], SMP_BITS'($urandom), 1'b0, '0, 1'b0);
            n++;
         end
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (gray_expect_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d starts, %0d writes, %0d reads, %0d unused-code transactions",
               n_start, n_write, n_read, n_unused);
      $display("checked %0d gray results (%0d with zero range), %0d mismatches",
               n_checked, n_zero, mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
